FILE: hdl/bdeq_pkg.sv
// Shared types and constants for the button debounce and event qualifier.
// Holds beat payload structs, event codes and register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bdeq_pkg;

  localparam int unsigned NumButtons = 3;
  localparam int unsigned CntW       = 8;
  localparam int unsigned TimerW     = 16;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned CfgIdxW    = 2;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE_LIMIT = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_LONG_PRESS     = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_IDLE_TIMEOUT   = 2'd2;

  // Register reset values
  localparam logic [CntW-1:0]   DebounceLimitRst = 8'd20;
  localparam logic [TimerW-1:0] LongPressRst     = 16'd1000;
  localparam logic [TimerW-1:0] IdleTimeoutRst   = 16'd20000;

  // Per-button event codes
  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PUSH    = 2'd1,
    EV_LONG    = 2'd2,
    EV_RELEASE = 2'd3
  } bdeq_event_e;

  // Input beat: raw active-low button levels
  typedef struct packed {
    logic ok_raw;
    logic right_raw;
    logic left_raw;
  } bdeq_in_t;

  // Output beat
  typedef struct packed {
    logic [1:0] ok_event;
    logic [1:0] right_event;
    logic [1:0] left_event;
    logic       idle_timeout;
    logic       ok_level;
  } bdeq_out_t;

  // What one lane reports for the current tick
  typedef struct packed {
    bdeq_event_e ev;
    logic        level;
  } bdeq_lane_res_t;

endpackage

`default_nettype wire

FILE: hdl/bdeq_lane.sv
// One button lane: saturating integrator filter and push/long/release machine.
// Depends on bdeq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bdeq_lane (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        tick_i,
  input  wire logic                        raw_i,
  input  wire logic [bdeq_pkg::CntW-1:0]   debounce_limit_i,
  input  wire logic [bdeq_pkg::TimerW-1:0] long_press_i,
  output bdeq_pkg::bdeq_lane_res_t         res_o
);
  import bdeq_pkg::*;

  typedef enum logic [1:0] {
    ST_WAIT    = 2'd0,
    ST_PRESSED = 2'd1,
    ST_LONG    = 2'd2
  } state_e;

  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              lvl_q, lvl_d;
  state_e            state_q, state_d;
  logic [TimerW-1:0] timer_q, timer_d;
  bdeq_event_e       ev;

  // Integrate the raw level; the filtered level moves only at the rails
  always_comb begin
    cnt_d = cnt_q;
    lvl_d = lvl_q;
    if (!raw_i) begin
      if (cnt_q < debounce_limit_i) cnt_d = cnt_q + 1'b1;
      else                          lvl_d = 1'b1;
    end else begin
      if (cnt_q != '0) cnt_d = cnt_q - 1'b1;
      else             lvl_d = 1'b0;
    end
  end

  // Qualify events from the freshly filtered level
  always_comb begin
    state_d = state_q;
    timer_d = timer_q + 1'b1;
    ev      = EV_NONE;
    unique case (state_q)
      ST_WAIT: begin
        timer_d = timer_q;
        if (lvl_d) begin
          state_d = ST_PRESSED;
          timer_d = '0;
          ev      = EV_PUSH;
        end
      end
      ST_PRESSED: begin
        if (!lvl_d) begin
          state_d = ST_WAIT;
          timer_d = '0;
          ev      = EV_RELEASE;
        end else if (timer_q == long_press_i) begin
          state_d = ST_LONG;
          timer_d = '0;
          ev      = EV_LONG;
        end
      end
      ST_LONG: begin
        if (!lvl_d) begin
          state_d = ST_WAIT;
          timer_d = '0;
          ev      = EV_RELEASE;
        end
      end
      default: begin
        // Unused code: fall back to waiting, timer restarts at one
        state_d = ST_WAIT;
        timer_d = {{(TimerW-1){1'b0}}, 1'b1};
      end
    endcase
  end

  assign res_o.ev    = ev;
  assign res_o.level = lvl_d;

  // Advance lane state once per accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      lvl_q   <= 1'b0;
      state_q <= ST_WAIT;
      timer_q <= '0;
    end else if (tick_i) begin
      cnt_q   <= cnt_d;
      lvl_q   <= lvl_d;
      state_q <= state_d;
      timer_q <= timer_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/bdeq_merge.sv
// Merge stage: combines lane events, runs the idle counter, holds the output beat.
// Depends on bdeq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bdeq_merge (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        tick_i,
  input  wire bdeq_pkg::bdeq_lane_res_t    lane_res_i [bdeq_pkg::NumButtons],
  input  wire logic [bdeq_pkg::TimerW-1:0] idle_timeout_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output bdeq_pkg::bdeq_out_t              out_data_o
);
  import bdeq_pkg::*;

  logic              any_ev;
  logic [TimerW-1:0] idle_q, idle_d;
  logic              timeout;
  logic              out_valid_q, out_valid_d;
  bdeq_out_t         out_q, out_d;

  // Detect any event across lanes
  always_comb begin
    any_ev = 1'b0;
    for (int i = 0; i < NumButtons; i++) begin
      if (lane_res_i[i].ev != EV_NONE) any_ev = 1'b1;
    end
  end

  // Idle counter: clear on activity, wrap and flag at the limit
  always_comb begin
    timeout = 1'b0;
    if (any_ev) begin
      idle_d = '0;
    end else if (idle_q == idle_timeout_i) begin
      idle_d  = '0;
      timeout = 1'b1;
    end else begin
      idle_d = idle_q + 1'b1;
    end
  end

  // Assemble the result beat
  always_comb begin
    out_d.ok_event     = lane_res_i[0].ev;
    out_d.right_event  = lane_res_i[1].ev;
    out_d.left_event   = lane_res_i[2].ev;
    out_d.idle_timeout = timeout;
    out_d.ok_level     = lane_res_i[0].level;
  end

  // Output register: load on a tick, drop once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (tick_i)                          out_valid_d = 1'b1;
    else if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (tick_i) idle_q <= idle_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_i) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: hdl/button_debounce_event_qualifier_top.sv
// An accepted tick loads the output register; its result beat shows in the next cycle.
// Throughput: one tick per cycle; the only hold-off is a stalled, full output register.
// Lanes filter all buttons in the same cycle; the merge stage sets the output timing.
// Reset clears integrators, levels, event machines, timers and idle counter, and loads
// the register defaults (debounce 20, long press 1000, idle timeout 20000).
// Top level: configuration registers, three button lanes and the merge stage.
// Depends on bdeq_pkg, bdeq_lane and bdeq_merge.
`timescale 1ns / 1ps
`default_nettype none

module button_debounce_event_qualifier_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire bdeq_pkg::bdeq_in_t            in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output bdeq_pkg::bdeq_out_t                out_data_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [bdeq_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [bdeq_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import bdeq_pkg::*;

  logic [CntW-1:0]   debounce_limit_q;
  logic [TimerW-1:0] long_press_q;
  logic [TimerW-1:0] idle_timeout_q;
  logic              tick;
  logic              raw [NumButtons];
  bdeq_lane_res_t    lane_res [NumButtons];

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_limit_q <= DebounceLimitRst;
      long_press_q     <= LongPressRst;
      idle_timeout_q   <= IdleTimeoutRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DEBOUNCE_LIMIT: debounce_limit_q <= cfg_wdata_i[CntW-1:0];
        REG_LONG_PRESS:     long_press_q     <= cfg_wdata_i[TimerW-1:0];
        REG_IDLE_TIMEOUT:   idle_timeout_q   <= cfg_wdata_i[TimerW-1:0];
        default: ;
      endcase
    end
  end

  // Hold the input only while the output beat is full and stalled
  assign in_stall_o = out_valid_o && out_stall_i;
  assign tick       = in_valid_i && !in_stall_o;

  assign raw[0] = in_data_i.ok_raw;
  assign raw[1] = in_data_i.right_raw;
  assign raw[2] = in_data_i.left_raw;

  for (genvar g = 0; g < NumButtons; g++) begin : g_lane
    bdeq_lane u_lane (
      .clk_i            (clk_i),
      .rst_ni           (rst_ni),
      .tick_i           (tick),
      .raw_i            (raw[g]),
      .debounce_limit_i (debounce_limit_q),
      .long_press_i     (long_press_q),
      .res_o            (lane_res[g])
    );
  end

  bdeq_merge u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .tick_i         (tick),
    .lane_res_i     (lane_res),
    .idle_timeout_i (idle_timeout_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_data_o     (out_data_o)
  );

endmodule

`default_nettype wire

FILE: hdl/bdeq_checker.sv
// Port-level checks for the debounce and event qualifier top level.
// Depends on bdeq_pkg; bound to button_debounce_event_qualifier_top below.
`timescale 1ns / 1ps
`default_nettype none

module bdeq_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  input  wire logic                          in_stall_o,
  input  wire logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  input  wire bdeq_pkg::bdeq_out_t           out_data_o
);
  import bdeq_pkg::*;

  // A stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output beat changed");

  // Input is held off only behind a full, stalled output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // Every accepted tick yields a beat in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted tick produced no result");

  // A fresh result only follows an accepted tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("result beat without an accepted tick");

  // Push comes with the first button pressed, release with it released
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.ok_event == EV_PUSH || out_data_o.ok_event == EV_RELEASE)
      |-> out_data_o.ok_level == (out_data_o.ok_event == EV_PUSH))
    else $error("first button event disagrees with its level");

endmodule

bind button_debounce_event_qualifier_top bdeq_checker u_bdeq_checker (.*);

`default_nettype wire

FILE: sim/tb_button_debounce_event_qualifier_top.sv
// Testbench for button_debounce_event_qualifier_top: drives tick beats, random gaps and stalls.
// A scoreboard class predicts each tick's events and checks every result beat in order.
// Depends on bdeq_pkg and the top level RTL.
`timescale 1ns / 1ps

import bdeq_pkg::*;

// Predicts the event beat for each accepted tick and checks result beats in order
class event_scoreboard;
  typedef enum logic [1:0] {
    ST_WAIT_PUSH,
    ST_PRESSED,
    ST_LONG_HELD,
    ST_UNUSED
  } press_state_e;

  logic [CntW-1:0]   deb_limit;
  logic [TimerW-1:0] long_ticks;
  logic [TimerW-1:0] idle_ticks;
  logic [CntW-1:0]   integ [NumButtons];
  logic              level [NumButtons];
  press_state_e      st [NumButtons];
  logic [TimerW-1:0] ptimer [NumButtons];
  logic [TimerW-1:0] idle_cnt;
  bdeq_out_t         expected_events [$];
  int                errors;
  int                beats;

  function new();
    deb_limit  = DebounceLimitRst;
    long_ticks = LongPressRst;
    idle_ticks = IdleTimeoutRst;
    for (int i = 0; i < NumButtons; i++) begin
      integ[i]  = '0;
      level[i]  = 1'b0;
      st[i]     = ST_WAIT_PUSH;
      ptimer[i] = '0;
    end
    idle_cnt = '0;
    errors   = 0;
    beats    = 0;
  endfunction

  // Mirror a register write; unknown indexes are dropped
  function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    case (idx)
      REG_DEBOUNCE_LIMIT: deb_limit  = data[CntW-1:0];
      REG_LONG_PRESS:     long_ticks = data;
      REG_IDLE_TIMEOUT:   idle_ticks = data;
      default: ;
    endcase
  endfunction

  // Advance the filters, event machines and idle counter by one tick
  function bdeq_out_t qualify_tick(bdeq_in_t t);
    logic        raw [NumButtons];
    bdeq_event_e ev [NumButtons];
    bdeq_out_t   r;
    bit          any;
    raw[0] = t.ok_raw;
    raw[1] = t.right_raw;
    raw[2] = t.left_raw;
    any    = 1'b0;
    // saturating integrators, raw level low means pressed
    for (int i = 0; i < NumButtons; i++) begin
      if (!raw[i]) begin
        if (integ[i] < deb_limit) integ[i] = integ[i] + 1'b1;
        else level[i] = 1'b1;
      end else begin
        if (integ[i] != '0) integ[i] = integ[i] - 1'b1;
        else level[i] = 1'b0;
      end
    end
    // push / long / release machines
    for (int i = 0; i < NumButtons; i++) begin
      ev[i] = EV_NONE;
      case (st[i])
        ST_WAIT_PUSH: begin
          if (level[i]) begin
            st[i]     = ST_PRESSED;
            ptimer[i] = '0;
            ev[i]     = EV_PUSH;
          end
        end
        ST_PRESSED: begin
          if (!level[i]) begin
            st[i]     = ST_WAIT_PUSH;
            ptimer[i] = '0;
            ev[i]     = EV_RELEASE;
          end else if (ptimer[i] == long_ticks) begin
            st[i]     = ST_LONG_HELD;
            ptimer[i] = '0;
            ev[i]     = EV_LONG;
          end else begin
            ptimer[i] = ptimer[i] + 1'b1;
          end
        end
        ST_LONG_HELD: begin
          if (!level[i]) begin
            st[i]     = ST_WAIT_PUSH;
            ptimer[i] = '0;
            ev[i]     = EV_RELEASE;
          end else begin
            ptimer[i] = ptimer[i] + 1'b1;
          end
        end
        default: begin
          st[i]     = ST_WAIT_PUSH;
          ptimer[i] = 16'd1;
        end
      endcase
      if (ev[i] != EV_NONE) any = 1'b1;
    end
    // idle timer: clear on any event, flag once the timeout value is reached
    r.idle_timeout = 1'b0;
    if (any) begin
      idle_cnt = '0;
    end else if (idle_cnt == idle_ticks) begin
      idle_cnt       = '0;
      r.idle_timeout = 1'b1;
    end else begin
      idle_cnt = idle_cnt + 1'b1;
    end
    r.ok_event    = ev[0];
    r.right_event = ev[1];
    r.left_event  = ev[2];
    r.ok_level    = level[0];
    return r;
  endfunction

  function void note_tick(bdeq_in_t t);
    expected_events.push_back(qualify_tick(t));
  endfunction

  function int pending();
    return expected_events.size();
  endfunction

  // Print one line per mismatch, keep the log bounded
  task report(string msg);
    if (errors < 50) $display("tb: mismatch: %s", msg);
    errors++;
  endtask

  task check_beat(bdeq_out_t got);
    bdeq_out_t want;
    if (expected_events.size() == 0) begin
      report($sformatf("result beat %h with no tick pending", got));
      return;
    end
    want = expected_events.pop_front();
    if (got.ok_event !== want.ok_event)
      report($sformatf("beat %0d ok_event %0d, want %0d", beats, got.ok_event, want.ok_event));
    if (got.right_event !== want.right_event)
      report($sformatf("beat %0d right_event %0d, want %0d", beats, got.right_event,
                       want.right_event));
    if (got.left_event !== want.left_event)
      report($sformatf("beat %0d left_event %0d, want %0d", beats, got.left_event,
                       want.left_event));
    if (got.idle_timeout !== want.idle_timeout)
      report($sformatf("beat %0d idle_timeout %b, want %b", beats, got.idle_timeout,
                       want.idle_timeout));
    if (got.ok_level !== want.ok_level)
      report($sformatf("beat %0d ok_level %b, want %b", beats, got.ok_level, want.ok_level));
    beats++;
  endtask
endclass

module tb_button_debounce_event_qualifier_top;

  localparam int HalfPeriod  = 6;
  localparam int QuietLimit  = 400;
  localparam int PhaseTicks  = 170;
  localparam int LongHold    = 300;
  localparam logic [CfgIdxW-1:0] REG_UNUSED = 2'd3;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  bdeq_in_t            in_data;
  logic                out_valid;
  logic                out_stall;
  bdeq_out_t           out_data;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  event_scoreboard sb;
  bit              idling_on;
  int              stall_left;
  int              quiet_cycles;
  logic            hold_raw [NumButtons];
  int              run_left [NumButtons];

  button_debounce_event_qualifier_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #HalfPeriod clk = ~clk;
  end

  // Check each accepted result beat and draw the next stall length
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_beat(out_data);
      stall_left = idling_on ? $urandom_range(0, 12) : 0;
    end
  end

  // Hold stall for the drawn number of cycles
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Drop the run when neither side moves a beat for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.set_reg(idx, data);
  endtask

  // Send one tick beat after a random gap and wait for it to be taken
  task automatic send_tick(bdeq_in_t t);
    int gap;
    gap = idling_on ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_data  <= bdeq_in_t'($urandom_range(0, 7));
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (in_stall);
    sb.note_tick(t);
  endtask

  task automatic send_run(bdeq_in_t t, int count);
    repeat (count) send_tick(t);
  endtask

  // Stop sending and wait for every predicted beat to come back
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Press/release runs per button with bounce noise, now and then a fully random tick
  function automatic bdeq_in_t next_pattern_tick();
    logic     b [NumButtons];
    bdeq_in_t t;
    int       max_run;
    if ($urandom_range(0, 24) == 0) return bdeq_in_t'($urandom_range(0, 7));
    max_run = 2 * (int'(sb.deb_limit) + int'(sb.long_ticks)) + 12;
    for (int i = 0; i < NumButtons; i++) begin
      if (run_left[i] == 0) begin
        hold_raw[i] = ~hold_raw[i];
        run_left[i] = $urandom_range(1, max_run);
      end
      run_left[i]--;
      b[i] = hold_raw[i] ^ ($urandom_range(0, 11) == 0);
    end
    t.ok_raw    = b[0];
    t.right_raw = b[1];
    t.left_raw  = b[2];
    return t;
  endfunction

  initial begin
    logic [7:0] hi;
    sb           = new();
    idling_on    = 1'b1;
    stall_left   = 0;
    quiet_cycles = 0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '1;
    out_stall    = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_wdata    = '0;
    for (int i = 0; i < NumButtons; i++) begin
      hold_raw[i] = 1'b1;
      run_left[i] = 0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset defaults; a write to an unknown index must leave them alone
    write_reg(REG_UNUSED, 16'hFFFF);
    send_run(3'b011, 22);
    wait_drained();

    // Zero debounce, zero long press, zero idle timeout; masked upper byte on debounce
    write_reg(REG_DEBOUNCE_LIMIT, 16'hAB00);
    write_reg(REG_LONG_PRESS, 16'h0000);
    write_reg(REG_IDLE_TIMEOUT, 16'h0000);
    send_tick(3'b111);
    send_tick(3'b111);
    send_tick(3'b000);
    send_tick(3'b000);
    send_tick(3'b000);
    send_tick(3'b101);
    send_tick(3'b010);
    send_tick(3'b110);
    send_tick(3'b001);
    send_run(3'b111, 3);
    wait_drained();

    // Widest settings: full debounce both ways, long press and idle timeout at their tops
    idling_on = 1'b0;
    write_reg(REG_DEBOUNCE_LIMIT, 16'h00FF);
    write_reg(REG_LONG_PRESS, 16'hFFFF);
    write_reg(REG_IDLE_TIMEOUT, 16'hFFFF);
    send_run(3'b011, LongHold);
    send_run(3'b111, LongHold);
    wait_drained();

    // Random phases over several settings
    for (int p = 0; p < 5; p++) begin
      idling_on = (p != 2);
      hi = $urandom_range(0, 255);
      if (p == 0) begin
        write_reg(REG_DEBOUNCE_LIMIT, {hi, 8'd1});
        write_reg(REG_LONG_PRESS, 16'd1);
        write_reg(REG_IDLE_TIMEOUT, 16'd1);
      end else begin
        write_reg(REG_DEBOUNCE_LIMIT,
                  {hi, (p == 3) ? 8'd0 : 8'($urandom_range(0, 6))});
        write_reg(REG_LONG_PRESS, 16'($urandom_range(0, 40)));
        write_reg(REG_IDLE_TIMEOUT, 16'($urandom_range(0, 80)));
      end
      for (int n = 0; n < PhaseTicks; n++) begin
        send_tick(next_pattern_tick());
        if ($urandom_range(0, 99) == 0) wait_drained();
      end
      wait_drained();
    end

    repeat (4) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
